FILE: rtl/core/bkrd_pkg.sv
// Shared constants and types for the boot keyboard report differ.
`timescale 1ns / 1ps
package bkrd_pkg;

	localparam int KEY_SLOTS     = 6;
	localparam int MODIFIER_BITS = 8;
	localparam int STAGE_DEPTH   = MODIFIER_BITS + 2 * KEY_SLOTS;
	localparam int MAX_RESULTS   = 20;

	localparam int SLOT_W = $clog2(KEY_SLOTS);
	localparam int IDX_W  = $clog2(STAGE_DEPTH);
	localparam int CNT_W  = $clog2(STAGE_DEPTH + 1);
	localparam int MOD_W  = (MODIFIER_BITS > 1) ? $clog2(MODIFIER_BITS) : 1;

	localparam logic [7:0] REPORT_BYTES   = 8'd8;
	localparam logic [7:0] MOD_USAGE_BASE = 8'hE0;
	localparam logic [7:0] USAGE_ROLLOVER = 8'h01;
	localparam logic [7:0] USAGE_POSTFAIL = 8'h02;
	localparam logic [7:0] USAGE_UNDEF    = 8'h03;

	localparam logic [4:0] CAP_RESET = 5'd20;

	localparam logic [2:0] KIND_ERROR       = 3'd0;
	localparam logic [2:0] KIND_MOD_PRESS   = 3'd1;
	localparam logic [2:0] KIND_MOD_RELEASE = 3'd2;
	localparam logic [2:0] KIND_KEY_RELEASE = 3'd3;
	localparam logic [2:0] KIND_KEY_PRESS   = 3'd4;
	localparam logic [2:0] KIND_OVERFLOW    = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_CHECK,
		ST_EMIT
	} state_t;

	typedef logic [7:0] usage_t;

	function automatic logic is_error_usage(input usage_t u);
		return (u == USAGE_ROLLOVER) || (u == USAGE_POSTFAIL) || (u == USAGE_UNDEF);
	endfunction

endpackage

FILE: rtl/core/boot_keyboard_report_differ_top.sv
// Top level of the boot keyboard report differ: sequencer, shared candidate compare and output register.
`timescale 1ns / 1ps
// Takes one 8-byte boot keyboard report per request and turns it into key events against the
// previously stored report. Each report is walked by one shared compare unit, one candidate
// per cycle while the output is not stalled: a counting pass and then, unless the report
// overflows or changes nothing, an emitting pass. A normal report has 20 candidates (8 modifier
// bits, 6 release slots, 6 press slots), a report holding error usages has 6. A report with a
// wrong length is dropped. The input is not ready while a report is being worked on. The event
// capacity register may be written only while idle.
module boot_keyboard_report_differ_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rpt_len,
	input  logic [7:0] new_modifiers,
	input  logic [7:0] key_slot_0,
	input  logic [7:0] key_slot_1,
	input  logic [7:0] key_slot_2,
	input  logic [7:0] key_slot_3,
	input  logic [7:0] key_slot_4,
	input  logic [7:0] key_slot_5,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_kind,
	output logic [7:0] event_usage,
	output logic [7:0] event_modifiers,
	output logic [4:0] event_total,
	output logic       last
);

	localparam int KS = bkrd_pkg::KEY_SLOTS;
	localparam int MB = bkrd_pkg::MODIFIER_BITS;
	localparam int SD = bkrd_pkg::STAGE_DEPTH;

	bkrd_pkg::state_t state_q, state_d;

	bkrd_pkg::usage_t in_keys [KS];
	bkrd_pkg::usage_t keys_q [KS];
	bkrd_pkg::usage_t prev_keys_q [KS];
	logic [7:0] mods_q;
	logic [7:0] prev_mods_q;
	logic [4:0] cap_q;
	logic       err_q;
	logic [bkrd_pkg::IDX_W-1:0] idx_q;
	logic [bkrd_pkg::CNT_W-1:0] cnt_q;
	logic [bkrd_pkg::CNT_W-1:0] sent_q;

	logic       out_valid_q;
	logic [2:0] kind_q;
	logic [7:0] usage_q;
	logic [7:0] omods_q;
	logic [4:0] total_q;
	logic       last_q;

	logic in_err;
	logic accept;
	logic len_ok;
	logic out_free;
	logic at_end;
	logic over_cap;
	logic [4:0] cap_eff;
	logic [bkrd_pkg::IDX_W-1:0] last_idx;

	// Control from the sequencer.
	logic start;
	logic count_step;
	logic emit_step;
	logic load_ovf;
	logic commit;

	// Shared candidate evaluation.
	logic cand_hit;
	logic [2:0] cand_kind;
	bkrd_pkg::usage_t cand_usage;
	logic [bkrd_pkg::SLOT_W-1:0] slot;
	logic is_rel;
	logic is_key;
	bkrd_pkg::usage_t u;
	logic dup;
	logic present;
	logic mod_was;
	logic mod_now;

	assign in_keys[0] = key_slot_0;
	assign in_keys[1] = key_slot_1;
	assign in_keys[2] = key_slot_2;
	assign in_keys[3] = key_slot_3;
	assign in_keys[4] = key_slot_4;
	assign in_keys[5] = key_slot_5;

	always_comb begin
		in_err = 1'b0;
		for (int i = 0; i < KS; i++) begin
			in_err = in_err | bkrd_pkg::is_error_usage(in_keys[i]);
		end
	end

	assign accept   = in_valid & in_ready;
	assign len_ok   = (rpt_len == bkrd_pkg::REPORT_BYTES);
	assign out_free = !out_valid_q || out_ready;
	assign last_idx = err_q ? bkrd_pkg::IDX_W'(KS - 1) : bkrd_pkg::IDX_W'(SD - 1);
	assign at_end   = (idx_q == last_idx);
	assign cap_eff  = (cap_q > 5'(bkrd_pkg::MAX_RESULTS)) ? 5'(bkrd_pkg::MAX_RESULTS) : cap_q;
	assign over_cap = (cnt_q > bkrd_pkg::CNT_W'(cap_eff));

	// One candidate per cycle unless stalled: modifier bit, release slot, press slot or error slot.
	always_comb begin
		slot   = '0;
		is_rel = 1'b0;
		is_key = 1'b0;
		for (int i = 0; i < KS; i++) begin
			if (err_q) begin
				if (idx_q == bkrd_pkg::IDX_W'(i)) begin
					slot = bkrd_pkg::SLOT_W'(i);
				end
			end else begin
				if (idx_q == bkrd_pkg::IDX_W'(MB + i)) begin
					slot   = bkrd_pkg::SLOT_W'(i);
					is_rel = 1'b1;
					is_key = 1'b1;
				end
				if (idx_q == bkrd_pkg::IDX_W'(MB + KS + i)) begin
					slot   = bkrd_pkg::SLOT_W'(i);
					is_key = 1'b1;
				end
			end
		end

		u = is_rel ? prev_keys_q[slot] : keys_q[slot];
		dup     = 1'b0;
		present = 1'b0;
		for (int j = 0; j < KS; j++) begin
			if (bkrd_pkg::SLOT_W'(j) < slot) begin
				dup = dup | (u == (is_rel ? prev_keys_q[j] : keys_q[j]));
			end
			present = present | (u == (is_rel ? keys_q[j] : prev_keys_q[j]));
		end

		mod_was = prev_mods_q[idx_q[bkrd_pkg::MOD_W-1:0]];
		mod_now = mods_q[idx_q[bkrd_pkg::MOD_W-1:0]];

		if (err_q) begin
			cand_hit   = bkrd_pkg::is_error_usage(u);
			cand_kind  = bkrd_pkg::KIND_ERROR;
			cand_usage = u;
		end else if (is_key) begin
			cand_hit   = (u != '0) && !dup && !present;
			cand_kind  = is_rel ? bkrd_pkg::KIND_KEY_RELEASE : bkrd_pkg::KIND_KEY_PRESS;
			cand_usage = u;
		end else begin
			cand_hit   = (mod_was != mod_now);
			cand_kind  = mod_now ? bkrd_pkg::KIND_MOD_PRESS : bkrd_pkg::KIND_MOD_RELEASE;
			cand_usage = bkrd_pkg::MOD_USAGE_BASE + 8'(idx_q);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bkrd_pkg::ST_IDLE: begin
				if (accept && len_ok) begin
					state_d = bkrd_pkg::ST_COUNT;
				end
			end
			bkrd_pkg::ST_COUNT: begin
				if (at_end) begin
					state_d = bkrd_pkg::ST_CHECK;
				end
			end
			bkrd_pkg::ST_CHECK: begin
				if (over_cap) begin
					if (out_free) begin
						state_d = bkrd_pkg::ST_IDLE;
					end
				end else if (cnt_q == '0) begin
					state_d = bkrd_pkg::ST_IDLE;
				end else begin
					state_d = bkrd_pkg::ST_EMIT;
				end
			end
			bkrd_pkg::ST_EMIT: begin
				if (out_free && at_end) begin
					state_d = bkrd_pkg::ST_IDLE;
				end
			end
			default: state_d = bkrd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready   = 1'b0;
		start      = 1'b0;
		count_step = 1'b0;
		emit_step  = 1'b0;
		load_ovf   = 1'b0;
		commit     = 1'b0;
		unique case (state_q)
			bkrd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				start    = accept && len_ok;
			end
			bkrd_pkg::ST_COUNT: begin
				count_step = 1'b1;
			end
			bkrd_pkg::ST_CHECK: begin
				load_ovf = over_cap && out_free;
				commit   = !over_cap && (cnt_q == '0) && !err_q;
			end
			bkrd_pkg::ST_EMIT: begin
				emit_step = out_free;
				commit    = out_free && at_end && !err_q;
			end
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bkrd_pkg::ST_IDLE;
			cap_q       <= bkrd_pkg::CAP_RESET;
			prev_mods_q <= '0;
			for (int i = 0; i < KS; i++) begin
				prev_keys_q[i] <= '0;
			end
			idx_q       <= '0;
			cnt_q       <= '0;
			sent_q      <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end

			if (start) begin
				err_q <= in_err;
				idx_q <= '0;
				cnt_q <= '0;
			end else if (count_step) begin
				cnt_q <= cnt_q + bkrd_pkg::CNT_W'(cand_hit);
				idx_q <= at_end ? '0 : idx_q + 1'b1;
			end else if (state_q == bkrd_pkg::ST_CHECK) begin
				sent_q <= '0;
			end else if (emit_step) begin
				sent_q <= sent_q + bkrd_pkg::CNT_W'(cand_hit);
				idx_q  <= at_end ? '0 : idx_q + 1'b1;
			end

			if (commit) begin
				prev_mods_q <= mods_q;
				for (int i = 0; i < KS; i++) begin
					prev_keys_q[i] <= keys_q[i];
				end
			end

			if (load_ovf || (emit_step && cand_hit)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Report and result payload.
	always_ff @(posedge clk) begin
		if (start) begin
			mods_q <= new_modifiers;
			for (int i = 0; i < KS; i++) begin
				keys_q[i] <= in_keys[i];
			end
		end
		if (load_ovf) begin
			kind_q  <= bkrd_pkg::KIND_OVERFLOW;
			usage_q <= '0;
			omods_q <= mods_q;
			total_q <= 5'(cnt_q);
			last_q  <= 1'b1;
		end else if (emit_step && cand_hit) begin
			kind_q  <= cand_kind;
			usage_q <= cand_usage;
			omods_q <= mods_q;
			total_q <= 5'(cnt_q);
			last_q  <= (sent_q + 1'b1 == cnt_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign event_kind      = kind_q;
	assign event_usage     = usage_q;
	assign event_modifiers = omods_q;
	assign event_total     = total_q;
	assign last            = last_q;

endmodule
